### rtl/rcsd_pkg.sv
// shared constants, types and helpers for the rc stick drive dome shaper
`timescale 1ns / 1ps
`default_nettype none

package rcsd_pkg;

   localparam int TIME_BITS      = 32;
   localparam int PULSE_BITS     = 16;
   localparam int CLAMP_BITS     = 11;
   localparam int CMD_BITS       = 8;
   localparam int MAG_BITS       = 7;
   localparam int DOME_MAG_BITS  = 9;
   localparam int GAIN_BITS      = 10;
   localparam int BOOST_BITS     = 15;
   localparam int CURVE_Q_BITS   = 12;

   localparam int ALU_A_BITS     = 33;
   localparam int ALU_B_BITS     = 21;
   localparam int MUL_BITS       = 9;
   localparam int QUO_BITS       = CURVE_Q_BITS;
   localparam int REM_BITS       = ALU_B_BITS + 1;
   localparam int ALU_CNT_BITS   = $clog2(QUO_BITS + 1);

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 10;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_EXPO_POWER      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DRIVE_LIMIT     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STICK_DEAD_ZONE = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DOME_DEAD_ZONE  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DOME_BOOST      = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DOME_LIMIT      = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DOME_LEFT_GAIN  = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DOME_RIGHT_GAIN = 3'd7;

   localparam logic ALU_MUL = 1'b0;
   localparam logic ALU_DIV = 1'b1;

   localparam logic [CLAMP_BITS-1:0] PULSE_MIN = 11'd1000;
   localparam logic [CLAMP_BITS-1:0] PULSE_MAX = 11'd2000;
   localparam logic [CLAMP_BITS-1:0] PULSE_MID = 11'd1500;

   localparam int STICK_SPAN      = 254;
   localparam int PULSE_SPAN      = 1000;
   localparam int DOME_STEP       = 5;
   localparam int DOME_SPAN       = 100;
   localparam int GAIN_SHIFT      = 8;
   localparam int STICK_FULL      = 127;
   localparam int TURN_CAP        = 100;
   localparam int TURN_CAP_DRIVE  = 40;
   localparam int FLICK_THRESHOLD = 5;
   localparam int FLICK_MS        = 40;

   localparam logic signed [CMD_BITS-1:0] FLICK_SPEED = 8'sd20;

   localparam logic [1:0] EXPO_RESET        = 2'd1;
   localparam logic [MAG_BITS-1:0] DRIVE_LIMIT_RESET = 7'd25;
   localparam logic [2:0] BOOST_RESET       = 3'd2;
   localparam logic [MAG_BITS-1:0] DOME_LIMIT_RESET  = 7'd100;
   localparam logic [GAIN_BITS-1:0] GAIN_RESET      = 10'd256;

   typedef struct packed {
      logic                  start;
      logic                  op;
      logic [ALU_A_BITS-1:0] a;
      logic [ALU_B_BITS-1:0] b;
   } alu_req_type;

   function automatic logic [CLAMP_BITS-1:0] clamp_pulse(input logic [PULSE_BITS-1:0] p);
      logic [CLAMP_BITS-1:0] c;
      if (p < PULSE_BITS'(PULSE_MIN)) begin
         c = PULSE_MIN;
      end else if (p > PULSE_BITS'(PULSE_MAX)) begin
         c = PULSE_MAX;
      end else begin
         c = p[CLAMP_BITS-1:0];
      end
      return c;
   endfunction

   // 127 to the power n
   function automatic logic [ALU_B_BITS-1:0] curve_den(input logic [1:0] n);
      logic [ALU_B_BITS-1:0] d;
      case (n)
         2'd2:    d = 21'd16129;
         2'd3:    d = 21'd2048383;
         default: d = 21'd127;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

### rtl/rc_stick_drive_dome_shaper.sv
// rc stick shaper top level: frame sequencer, config registers and dome state
//
// Usage:
//   req_* carries one control frame (three pulse widths, kill, ms time).
//   rsp_* returns one command set per frame: drive, turn, dome, dome changed.
//   csr_* writes config register csr_index with csr_data; always ready.
//   User must write only while no frame is in progress; block won't enforce.
//   req_ready is high while the sequencer is idle; a frame may be taken
//   while the previous result still waits in the output register.
//   The time from acceptance to rsp_valid is set by the shared bit-serial
//   ALU: a multiply works one multiplier bit per cycle, a divide one
//   quotient bit per cycle, and a frame runs 13 to 19 of them in turn,
//   more for a larger effective curve exponent n (1..3).
//   Frames do not overlap: the next frame is taken only once the
//   sequencer is back in idle after posting the last result.
//   If the last result still waits with rsp_ready low when the next is done,
//   the sequencer holds in its last step; dome state is not updated until it can post.
//   Reset loads the config defaults, clears the flick state and the last
//   sent dome value, and drops rsp_valid.
`timescale 1ns / 1ps
`default_nettype none

module rc_stick_drive_dome_shaper (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [rcsd_pkg::PULSE_BITS-1:0]       req_turn_pulse_us,
   input  logic [rcsd_pkg::PULSE_BITS-1:0]       req_drive_pulse_us,
   input  logic [rcsd_pkg::PULSE_BITS-1:0]       req_dome_pulse_us,
   input  logic                                  req_kill_active,
   input  logic [rcsd_pkg::TIME_BITS-1:0]        req_time_ms,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [rcsd_pkg::CMD_BITS-1:0]  rsp_drive_cmd,
   output logic signed [rcsd_pkg::CMD_BITS-1:0]  rsp_turn_cmd,
   output logic signed [rcsd_pkg::CMD_BITS-1:0]  rsp_dome_cmd,
   output logic                                  rsp_dome_changed,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rcsd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [rcsd_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import rcsd_pkg::*;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_TURN_MUL  = 4'd1;
   localparam logic [3:0] S_TURN_DIV  = 4'd2;
   localparam logic [3:0] S_DRIVE_MUL = 4'd3;
   localparam logic [3:0] S_DRIVE_DIV = 4'd4;
   localparam logic [3:0] S_DOME_DIV  = 4'd5;
   localparam logic [3:0] S_DOME_MUL  = 4'd6;
   localparam logic [3:0] S_SHAPE     = 4'd7;
   localparam logic [3:0] S_CURVE_MUL = 4'd8;
   localparam logic [3:0] S_CURVE_DIV = 4'd9;
   localparam logic [3:0] S_BOOST     = 4'd10;
   localparam logic [3:0] S_FINISH    = 4'd11;

   localparam logic [1:0] SEL_DOME  = 2'd0;
   localparam logic [1:0] SEL_DRIVE = 2'd1;
   localparam logic [1:0] SEL_TURN  = 2'd2;

   // control
   logic [3:0] state_ff, state_in;
   logic       issued_ff, issued_in;
   logic [1:0] sel_ff, sel_in;
   logic [1:0] pow_ff, pow_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // config
   logic [1:0]           expo_ff, expo_in;
   logic [MAG_BITS-1:0]  drive_limit_ff, drive_limit_in;
   logic [MAG_BITS-1:0]  stick_dz_ff, stick_dz_in;
   logic [MAG_BITS-1:0]  dome_dz_ff, dome_dz_in;
   logic [2:0]           boost_ff, boost_in;
   logic [MAG_BITS-1:0]  dome_limit_ff, dome_limit_in;
   logic [GAIN_BITS-1:0] left_gain_ff, left_gain_in;
   logic [GAIN_BITS-1:0] right_gain_ff, right_gain_in;

   // dome state
   logic                        flick_held_ff, flick_held_in;
   logic [TIME_BITS-1:0]        flick_start_ff, flick_start_in;
   logic signed [CMD_BITS-1:0]  last_dome_ff, last_dome_in;

   // frame data
   logic [CLAMP_BITS-1:0]    turn_c_ff, turn_c_in;
   logic [CLAMP_BITS-1:0]    drive_c_ff, drive_c_in;
   logic [CLAMP_BITS-1:0]    dome_c_ff, dome_c_in;
   logic                     kill_ff, kill_in;
   logic [TIME_BITS-1:0]     time_ff, time_in;
   logic [CMD_BITS-1:0]      turn_m_ff, turn_m_in;
   logic [CMD_BITS-1:0]      drive_m_ff, drive_m_in;
   logic [DOME_MAG_BITS-1:0] dome_mag_ff, dome_mag_in;
   logic                     dome_neg_ff, dome_neg_in;
   logic [MAG_BITS-1:0]      turn_mag_ff, turn_mag_in;
   logic                     turn_neg_ff, turn_neg_in;
   logic [MAG_BITS-1:0]      drive_mag_ff, drive_mag_in;
   logic                     drive_neg_ff, drive_neg_in;
   logic [MAG_BITS-1:0]      drive_q_ff, drive_q_in;
   logic [MAG_BITS-1:0]      turn_q_ff, turn_q_in;
   logic [CURVE_Q_BITS-1:0]  dome_q_ff, dome_q_in;

   // result
   logic [CMD_BITS-1:0]         drive_cmd_ff, drive_cmd_in;
   logic [CMD_BITS-1:0]         turn_cmd_ff, turn_cmd_in;
   logic signed [CMD_BITS-1:0]  dome_cmd_ff, dome_cmd_in;
   logic                        changed_ff, changed_in;

   // alu
   alu_req_type            alu_req;
   logic                   alu_start;
   logic                   alu_op;
   logic [ALU_A_BITS-1:0]  alu_a;
   logic [ALU_B_BITS-1:0]  alu_b;
   logic                   alu_busy;
   logic                   alu_done;
   logic [ALU_A_BITS-1:0]  alu_result;

   // datapath helpers
   logic                       req_fire;
   logic                       dome_pos;
   logic [1:0]                 n_eff;
   logic [MUL_BITS-1:0]        curve_mag;
   logic [MAG_BITS-1:0]        curve_lim;
   logic [MAG_BITS-1:0]        drive_abs;
   logic [MAG_BITS-1:0]        turn_abs;
   logic [MAG_BITS-1:0]        drive_shaped;
   logic [MAG_BITS-1:0]        turn_shaped;
   logic                       finish_fire;
   logic [BOOST_BITS-1:0]      curved_mag;
   logic                       released;
   logic [TIME_BITS-1:0]       elapsed;
   logic                       coasting;
   logic signed [CMD_BITS-1:0] last_clamped;
   logic [MAG_BITS-1:0]        dome_sat;
   logic signed [CMD_BITS-1:0] dome_curved;
   logic signed [CMD_BITS-1:0] dome_now;

   assign req_ready   = (state_ff == S_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign csr_ready   = 1'b1;
   assign dome_pos    = (dome_c_ff >= PULSE_MID);
   assign n_eff       = (expo_ff == 2'd0) ? 2'd1 : expo_ff;
   assign finish_fire = !(rsp_valid_ff && !rsp_ready);

   always_comb begin
      curve_mag = MUL_BITS'(dome_mag_ff);
      curve_lim = dome_limit_ff;
      if (sel_ff == SEL_DRIVE) begin
         curve_mag = MUL_BITS'(drive_mag_ff);
         curve_lim = drive_limit_ff;
      end else if (sel_ff == SEL_TURN) begin
         curve_mag = MUL_BITS'(turn_mag_ff);
         curve_lim = drive_limit_ff;
      end
   end

   // dead zone and turn cap
   always_comb begin
      drive_abs = drive_m_ff[CMD_BITS-1] ? MAG_BITS'(-drive_m_ff) : drive_m_ff[MAG_BITS-1:0];
      turn_abs  = turn_m_ff[CMD_BITS-1] ? MAG_BITS'(-turn_m_ff) : turn_m_ff[MAG_BITS-1:0];
      drive_shaped = (drive_abs <= stick_dz_ff) ? '0 : drive_abs;
      turn_shaped  = (turn_abs <= stick_dz_ff) ? '0 : turn_abs;
      if (drive_shaped > MAG_BITS'(TURN_CAP_DRIVE) && turn_shaped > MAG_BITS'(TURN_CAP)) begin
         turn_shaped = MAG_BITS'(TURN_CAP);
      end
   end

   // dome update
   always_comb begin
      curved_mag = kill_ff ? '0 : alu_result[BOOST_BITS-1:0];
      released   = (dome_mag_ff < DOME_MAG_BITS'(dome_dz_ff));
      elapsed    = time_ff - flick_start_ff;
      coasting   = flick_held_ff && (elapsed < TIME_BITS'(FLICK_MS));
      if (last_dome_ff > FLICK_SPEED) begin
         last_clamped = FLICK_SPEED;
      end else if (last_dome_ff < -FLICK_SPEED) begin
         last_clamped = -FLICK_SPEED;
      end else begin
         last_clamped = last_dome_ff;
      end
      dome_sat    = (curved_mag > BOOST_BITS'(STICK_FULL)) ? MAG_BITS'(STICK_FULL)
                                                           : curved_mag[MAG_BITS-1:0];
      dome_curved = dome_neg_ff ? -$signed({1'b0, dome_sat}) : $signed({1'b0, dome_sat});
      if (released) begin
         dome_now = coasting ? last_clamped : '0;
      end else begin
         dome_now = dome_curved;
      end
   end

   // alu operand select
   always_comb begin
      alu_op = ALU_MUL;
      alu_a  = '0;
      alu_b  = '0;
      unique case (state_ff)
         S_TURN_MUL: begin
            alu_a = ALU_A_BITS'(turn_c_ff - PULSE_MIN);
            alu_b = ALU_B_BITS'(STICK_SPAN);
         end
         S_DRIVE_MUL: begin
            alu_a = ALU_A_BITS'(drive_c_ff - PULSE_MIN);
            alu_b = ALU_B_BITS'(STICK_SPAN);
         end
         S_TURN_DIV, S_DRIVE_DIV: begin
            alu_op = ALU_DIV;
            alu_a  = alu_result;
            alu_b  = ALU_B_BITS'(PULSE_SPAN);
         end
         S_DOME_DIV: begin
            alu_op = ALU_DIV;
            alu_a  = dome_pos ? ALU_A_BITS'(dome_c_ff - PULSE_MID)
                              : ALU_A_BITS'(dome_c_ff - PULSE_MIN);
            alu_b  = ALU_B_BITS'(DOME_STEP);
         end
         S_DOME_MUL: begin
            alu_a = dome_pos ? ALU_A_BITS'(right_gain_ff) : ALU_A_BITS'(left_gain_ff);
            alu_b = dome_pos ? ALU_B_BITS'(alu_result[MAG_BITS-1:0])
                             : ALU_B_BITS'(MAG_BITS'(DOME_SPAN) - alu_result[MAG_BITS-1:0]);
         end
         S_CURVE_MUL: begin
            alu_a = (pow_ff == 2'd0) ? ALU_A_BITS'(curve_lim) : alu_result;
            alu_b = ALU_B_BITS'(curve_mag);
         end
         S_CURVE_DIV: begin
            alu_op = ALU_DIV;
            alu_a  = alu_result;
            alu_b  = curve_den(n_eff);
         end
         S_BOOST: begin
            alu_a = ALU_A_BITS'(dome_q_ff);
            alu_b = flick_held_ff ? ALU_B_BITS'(1) : ALU_B_BITS'(boost_ff);
         end
         default: begin
            alu_op = ALU_MUL;
         end
      endcase
   end

   assign alu_req = '{start: alu_start, op: alu_op, a: alu_a, b: alu_b};

   // sequencer and state updates
   always_comb begin
      state_in       = state_ff;
      issued_in      = issued_ff;
      sel_in         = sel_ff;
      pow_in         = pow_ff;
      rsp_valid_in   = rsp_valid_ff;
      alu_start      = 1'b0;
      expo_in        = expo_ff;
      drive_limit_in = drive_limit_ff;
      stick_dz_in    = stick_dz_ff;
      dome_dz_in     = dome_dz_ff;
      boost_in       = boost_ff;
      dome_limit_in  = dome_limit_ff;
      left_gain_in   = left_gain_ff;
      right_gain_in  = right_gain_ff;
      flick_held_in  = flick_held_ff;
      flick_start_in = flick_start_ff;
      last_dome_in   = last_dome_ff;
      turn_c_in      = turn_c_ff;
      drive_c_in     = drive_c_ff;
      dome_c_in      = dome_c_ff;
      kill_in        = kill_ff;
      time_in        = time_ff;
      turn_m_in      = turn_m_ff;
      drive_m_in     = drive_m_ff;
      dome_mag_in    = dome_mag_ff;
      dome_neg_in    = dome_neg_ff;
      turn_mag_in    = turn_mag_ff;
      turn_neg_in    = turn_neg_ff;
      drive_mag_in   = drive_mag_ff;
      drive_neg_in   = drive_neg_ff;
      drive_q_in     = drive_q_ff;
      turn_q_in      = turn_q_ff;
      dome_q_in      = dome_q_ff;
      drive_cmd_in   = drive_cmd_ff;
      turn_cmd_in    = turn_cmd_ff;
      dome_cmd_in    = dome_cmd_ff;
      changed_in     = changed_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_EXPO_POWER:      expo_in        = csr_data[1:0];
            CSR_DRIVE_LIMIT:     drive_limit_in = csr_data[MAG_BITS-1:0];
            CSR_STICK_DEAD_ZONE: stick_dz_in    = csr_data[MAG_BITS-1:0];
            CSR_DOME_DEAD_ZONE:  dome_dz_in     = csr_data[MAG_BITS-1:0];
            CSR_DOME_BOOST:      boost_in       = csr_data[2:0];
            CSR_DOME_LIMIT:      dome_limit_in  = csr_data[MAG_BITS-1:0];
            CSR_DOME_LEFT_GAIN:  left_gain_in   = csr_data;
            CSR_DOME_RIGHT_GAIN: right_gain_in  = csr_data;
            default:             expo_in        = expo_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               turn_c_in  = clamp_pulse(req_turn_pulse_us);
               drive_c_in = clamp_pulse(req_drive_pulse_us);
               dome_c_in  = clamp_pulse(req_dome_pulse_us);
               kill_in    = req_kill_active;
               time_in    = req_time_ms;
               issued_in  = 1'b0;
               state_in   = S_TURN_MUL;
            end
         end
         S_TURN_MUL, S_TURN_DIV, S_DRIVE_MUL, S_DRIVE_DIV, S_DOME_DIV, S_DOME_MUL,
         S_CURVE_MUL, S_CURVE_DIV, S_BOOST: begin
            if (!issued_ff) begin
               alu_start = 1'b1;
               issued_in = 1'b1;
            end else if (alu_done) begin
               issued_in = 1'b0;
               unique case (state_ff)
                  S_TURN_MUL:  state_in = S_TURN_DIV;
                  S_TURN_DIV: begin
                     turn_m_in = alu_result[CMD_BITS-1:0] - CMD_BITS'(STICK_FULL);
                     state_in  = S_DRIVE_MUL;
                  end
                  S_DRIVE_MUL: state_in = S_DRIVE_DIV;
                  S_DRIVE_DIV: begin
                     drive_m_in = alu_result[CMD_BITS-1:0] - CMD_BITS'(STICK_FULL);
                     state_in   = S_DOME_DIV;
                  end
                  S_DOME_DIV:  state_in = S_DOME_MUL;
                  S_DOME_MUL: begin
                     dome_mag_in = alu_result[GAIN_SHIFT +: DOME_MAG_BITS];
                     dome_neg_in = !dome_pos;
                     state_in    = S_SHAPE;
                  end
                  S_CURVE_MUL: begin
                     if (2'(pow_ff + 2'd1) == n_eff) begin
                        pow_in   = 2'd0;
                        state_in = S_CURVE_DIV;
                     end else begin
                        pow_in = 2'(pow_ff + 2'd1);
                     end
                  end
                  S_CURVE_DIV: begin
                     if (sel_ff == SEL_DOME) begin
                        dome_q_in = alu_result[CURVE_Q_BITS-1:0];
                     end else if (sel_ff == SEL_DRIVE) begin
                        drive_q_in = alu_result[MAG_BITS-1:0];
                     end else begin
                        turn_q_in = alu_result[MAG_BITS-1:0];
                     end
                     if (sel_ff == SEL_TURN) begin
                        state_in = S_BOOST;
                     end else begin
                        sel_in   = 2'(sel_ff + 2'd1);
                        state_in = S_CURVE_MUL;
                     end
                  end
                  default: state_in = S_FINISH;
               endcase
            end
         end
         S_SHAPE: begin
            drive_mag_in = drive_shaped;
            drive_neg_in = drive_m_ff[CMD_BITS-1];
            turn_mag_in  = turn_shaped;
            turn_neg_in  = turn_m_ff[CMD_BITS-1];
            sel_in       = SEL_DOME;
            pow_in       = 2'd0;
            state_in     = S_CURVE_MUL;
         end
         S_FINISH: begin
            if (finish_fire) begin
               if (kill_ff) begin
                  drive_cmd_in = '0;
                  turn_cmd_in  = '0;
               end else begin
                  drive_cmd_in = drive_neg_ff ? -{1'b0, drive_q_ff} : {1'b0, drive_q_ff};
                  turn_cmd_in  = turn_neg_ff ? -{1'b0, turn_q_ff} : {1'b0, turn_q_ff};
               end
               dome_cmd_in  = dome_now;
               changed_in   = (dome_now != last_dome_ff);
               last_dome_in = dome_now;
               if (released) begin
                  if (!coasting) begin
                     flick_held_in = 1'b0;
                  end
               end else if (curved_mag >= BOOST_BITS'(FLICK_THRESHOLD)) begin
                  flick_start_in = time_ff;
                  flick_held_in  = 1'b1;
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         issued_ff      <= 1'b0;
         sel_ff         <= SEL_DOME;
         pow_ff         <= 2'd0;
         rsp_valid_ff   <= 1'b0;
         expo_ff        <= EXPO_RESET;
         drive_limit_ff <= DRIVE_LIMIT_RESET;
         stick_dz_ff    <= '0;
         dome_dz_ff     <= '0;
         boost_ff       <= BOOST_RESET;
         dome_limit_ff  <= DOME_LIMIT_RESET;
         left_gain_ff   <= GAIN_RESET;
         right_gain_ff  <= GAIN_RESET;
         flick_held_ff  <= 1'b0;
         flick_start_ff <= '0;
         last_dome_ff   <= '0;
      end else begin
         state_ff       <= state_in;
         issued_ff      <= issued_in;
         sel_ff         <= sel_in;
         pow_ff         <= pow_in;
         rsp_valid_ff   <= rsp_valid_in;
         expo_ff        <= expo_in;
         drive_limit_ff <= drive_limit_in;
         stick_dz_ff    <= stick_dz_in;
         dome_dz_ff     <= dome_dz_in;
         boost_ff       <= boost_in;
         dome_limit_ff  <= dome_limit_in;
         left_gain_ff   <= left_gain_in;
         right_gain_ff  <= right_gain_in;
         flick_held_ff  <= flick_held_in;
         flick_start_ff <= flick_start_in;
         last_dome_ff   <= last_dome_in;
      end
   end

   always_ff @(posedge clock) begin
      turn_c_ff    <= turn_c_in;
      drive_c_ff   <= drive_c_in;
      dome_c_ff    <= dome_c_in;
      kill_ff      <= kill_in;
      time_ff      <= time_in;
      turn_m_ff    <= turn_m_in;
      drive_m_ff   <= drive_m_in;
      dome_mag_ff  <= dome_mag_in;
      dome_neg_ff  <= dome_neg_in;
      turn_mag_ff  <= turn_mag_in;
      turn_neg_ff  <= turn_neg_in;
      drive_mag_ff <= drive_mag_in;
      drive_neg_ff <= drive_neg_in;
      drive_q_ff   <= drive_q_in;
      turn_q_ff    <= turn_q_in;
      dome_q_ff    <= dome_q_in;
      drive_cmd_ff <= drive_cmd_in;
      turn_cmd_ff  <= turn_cmd_in;
      dome_cmd_ff  <= dome_cmd_in;
      changed_ff   <= changed_in;
   end

   rcsd_serial_alu u_alu (
      .clock      (clock),
      .reset      (reset),
      .alu_req    (alu_req),
      .alu_busy   (alu_busy),
      .alu_done   (alu_done),
      .alu_result (alu_result)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_drive_cmd    = drive_cmd_ff;
   assign rsp_turn_cmd     = turn_cmd_ff;
   assign rsp_dome_cmd     = dome_cmd_ff;
   assign rsp_dome_changed = changed_ff;

   a_alu_starts: assert property (@(posedge clock) disable iff (reset)
      alu_req.start |=> alu_busy)
      else $error("alu not busy after start");

   a_dome_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (dome_cmd_ff != 8'sh80))
      else $error("dome command out of range");

   a_kill_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && finish_fire && kill_ff)
      |=> (drive_cmd_ff == '0 && turn_cmd_ff == '0))
      else $error("drive or turn nonzero under kill");

   a_changed_flag: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && finish_fire)
      |=> (changed_ff == (dome_cmd_ff != $past(last_dome_ff))))
      else $error("dome changed flag mismatch");

   a_coast_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && finish_fire && released)
      |=> (dome_cmd_ff <= FLICK_SPEED && dome_cmd_ff >= -FLICK_SPEED))
      else $error("coast speed out of bound");

endmodule

`default_nettype wire

### rtl/rcsd_serial_alu.sv
// bit-serial shift-add multiplier and restoring divider shared by the shaper
`timescale 1ns / 1ps
`default_nettype none

module rcsd_serial_alu (
   input  logic                             clock,
   input  logic                             reset,
   input  rcsd_pkg::alu_req_type            alu_req,
   output logic                             alu_busy,
   output logic                             alu_done,
   output logic [rcsd_pkg::ALU_A_BITS-1:0]  alu_result
);
   import rcsd_pkg::*;

   logic [ALU_CNT_BITS-1:0] count_ff, count_in;
   logic                    done_ff, done_in;
   logic                    op_ff, op_in;
   logic [ALU_A_BITS-1:0]   acc_ff, acc_in;
   logic [ALU_A_BITS-1:0]   mcand_ff, mcand_in;
   logic [MUL_BITS-1:0]     mplier_ff, mplier_in;
   logic [REM_BITS-1:0]     rem_ff, rem_in;
   logic [QUO_BITS-1:0]     quo_ff, quo_in;
   logic [ALU_B_BITS-1:0]   div_ff, div_in;
   logic [REM_BITS-1:0]     shifted;
   logic [REM_BITS:0]       diff;

   assign shifted = {rem_ff[REM_BITS-2:0], quo_ff[QUO_BITS-1]};
   assign diff    = {1'b0, shifted} - {2'b00, div_ff};

   always_comb begin
      count_in  = count_ff;
      done_in   = 1'b0;
      op_in     = op_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      div_in    = div_ff;
      if (alu_req.start) begin
         op_in = alu_req.op;
         if (alu_req.op == ALU_MUL) begin
            count_in  = ALU_CNT_BITS'(MUL_BITS);
            acc_in    = '0;
            mcand_in  = alu_req.a;
            mplier_in = alu_req.b[MUL_BITS-1:0];
         end else begin
            count_in = ALU_CNT_BITS'(QUO_BITS);
            rem_in   = REM_BITS'(alu_req.a >> QUO_BITS);
            quo_in   = alu_req.a[QUO_BITS-1:0];
            div_in   = alu_req.b;
         end
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == ALU_CNT_BITS'(1));
         if (op_ff == ALU_MUL) begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = {mcand_ff[ALU_A_BITS-2:0], 1'b0};
            mplier_in = mplier_ff >> 1;
         end else begin
            if (!diff[REM_BITS]) begin
               rem_in = diff[REM_BITS-1:0];
               quo_in = {quo_ff[QUO_BITS-2:0], 1'b1};
            end else begin
               rem_in = shifted;
               quo_in = {quo_ff[QUO_BITS-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      div_ff    <= div_in;
   end

   assign alu_busy   = (count_ff != '0);
   assign alu_done   = done_ff;
   assign alu_result = (op_ff == ALU_DIV) ? ALU_A_BITS'(quo_ff) : acc_ff;

endmodule

`default_nettype wire

### verif/rc_stick_drive_dome_shaper_tb.sv
// self-checking testbench for the rc stick drive dome shaper with a frame predictor
`timescale 1ns / 1ps

module rc_stick_drive_dome_shaper_tb;
   import rcsd_pkg::*;

   localparam int CYCLE_LIMIT   = 2000000;
   localparam int SETTLE_CYCLES = 300;
   localparam int LONG_HOLD     = 1500;

   typedef struct {
      logic [PULSE_BITS-1:0] turn_p;
      logic [PULSE_BITS-1:0] drive_p;
      logic [PULSE_BITS-1:0] dome_p;
      logic                  kill;
      logic [TIME_BITS-1:0]  now;
      logic [2:0]            gap;
      logic                  drain_first;
   } frame_type;

   typedef struct {
      logic signed [CMD_BITS-1:0] drive;
      logic signed [CMD_BITS-1:0] turn;
      logic signed [CMD_BITS-1:0] dome;
      logic                       changed;
   } cmd_set_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [PULSE_BITS-1:0]     req_turn_pulse_us = '0;
   logic [PULSE_BITS-1:0]     req_drive_pulse_us = '0;
   logic [PULSE_BITS-1:0]     req_dome_pulse_us = '0;
   logic                      req_kill_active = 1'b0;
   logic [TIME_BITS-1:0]      req_time_ms = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [CMD_BITS-1:0] rsp_drive_cmd;
   logic signed [CMD_BITS-1:0] rsp_turn_cmd;
   logic signed [CMD_BITS-1:0] rsp_dome_cmd;
   logic                      rsp_dome_changed;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   rc_stick_drive_dome_shaper dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_turn_pulse_us  (req_turn_pulse_us),
      .req_drive_pulse_us (req_drive_pulse_us),
      .req_dome_pulse_us  (req_dome_pulse_us),
      .req_kill_active    (req_kill_active),
      .req_time_ms        (req_time_ms),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_drive_cmd      (rsp_drive_cmd),
      .rsp_turn_cmd       (rsp_turn_cmd),
      .rsp_dome_cmd       (rsp_dome_cmd),
      .rsp_dome_changed   (rsp_dome_changed),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // config shadow and dome state of the predictor
   logic [1:0]           cfg_expo = 2'd1;
   logic [6:0]           cfg_drive_limit = 7'd25;
   logic [6:0]           cfg_stick_dz = 7'd0;
   logic [6:0]           cfg_dome_dz = 7'd0;
   logic [2:0]           cfg_boost = 3'd2;
   logic [6:0]           cfg_dome_limit = 7'd100;
   logic [9:0]           cfg_left_gain = 10'd256;
   logic [9:0]           cfg_right_gain = 10'd256;
   logic                 flick_held = 1'b0;
   logic [TIME_BITS-1:0] flick_start_ms = '0;
   int                   last_dome = 0;

   frame_type   frame_q[$];
   cmd_set_type cmd_expect_q[$];
   frame_type   staged_frame;
   bit       staged = 0;
   int       gap_left = 0;
   int       sent_count = 0;
   int       got_count = 0;
   int       rx_stall = 0;
   bit       rx_quiet = 0;
   int       error_count = 0;
   int       cycle_count = 0;
   logic [TIME_BITS-1:0] now_ms = '0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int iabs(input int v);
      return v < 0 ? -v : v;
   endfunction

   function automatic int clamp_range(input int v, input int lo, input int hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic int pulse_clamped(input logic [PULSE_BITS-1:0] p);
      return clamp_range(int'(p), 1000, 2000);
   endfunction

   function automatic int stick_pos(input logic [PULSE_BITS-1:0] p);
      return ((pulse_clamped(p) - 1000) * 254) / 1000 - 127;
   endfunction

   function automatic int dome_pos(input logic [PULSE_BITS-1:0] p);
      int c;
      c = pulse_clamped(p);
      if (c >= 1500) begin
         return (((c - 1500) / 5) * int'(cfg_right_gain)) / 256;
      end
      return -(((100 - (c - 1000) / 5) * int'(cfg_left_gain)) / 256);
   endfunction

   function automatic int expo_curve(input int x, input int lim);
      int     n, k;
      longint mag, num, den, q;
      n = (cfg_expo == 2'd0) ? 1 : int'(cfg_expo);
      mag = iabs(x);
      num = lim;
      den = 1;
      for (k = 0; k < n; k++) begin
         num = num * mag;
         den = den * 127;
      end
      q = num / den;
      return x >= 0 ? int'(q) : -int'(q);
   endfunction

   function automatic cmd_set_type shape_frame(input frame_type f);
      int                   turn_v, drive_v, dome_in, dome_curved, dome_now, cd, ct;
      logic [TIME_BITS-1:0] since;
      cmd_set_type          r;
      turn_v = stick_pos(f.turn_p);
      drive_v = stick_pos(f.drive_p);
      dome_in = dome_pos(f.dome_p);
      if (iabs(drive_v) <= int'(cfg_stick_dz)) drive_v = 0;
      if (iabs(turn_v) <= int'(cfg_stick_dz)) turn_v = 0;
      if (iabs(drive_v) > 40) turn_v = clamp_range(turn_v, -100, 100);
      dome_curved = expo_curve(dome_in, int'(cfg_dome_limit));
      if (!flick_held) dome_curved = dome_curved * int'(cfg_boost);
      cd = expo_curve(drive_v, int'(cfg_drive_limit));
      ct = expo_curve(turn_v, int'(cfg_drive_limit));
      if (f.kill) begin
         cd = 0;
         ct = 0;
         dome_curved = 0;
      end
      if (iabs(dome_in) < int'(cfg_dome_dz)) begin
         since = f.now - flick_start_ms;
         if (flick_held && since < 40) begin
            dome_now = clamp_range(last_dome, -20, 20);
         end else begin
            dome_now = 0;
            flick_held = 1'b0;
         end
      end else begin
         dome_now = dome_curved;
         if (iabs(dome_curved) >= 5) begin
            flick_start_ms = f.now;
            flick_held = 1'b1;
         end
      end
      dome_now = clamp_range(dome_now, -127, 127);
      r.drive = CMD_BITS'(cd);
      r.turn = CMD_BITS'(ct);
      r.dome = CMD_BITS'(dome_now);
      r.changed = (dome_now != last_dome);
      last_dome = dome_now;
      return r;
   endfunction

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("%s", msg);
      end
   endtask

   // driver
   always @(posedge clock) begin
      bit        busy;
      bit        accepted;
      int        in_flight;
      frame_type cur;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         busy = req_valid;
         accepted = req_valid && req_ready;
         if (accepted) begin
            cur.turn_p = req_turn_pulse_us;
            cur.drive_p = req_drive_pulse_us;
            cur.dome_p = req_dome_pulse_us;
            cur.kill = req_kill_active;
            cur.now = req_time_ms;
            cmd_expect_q.push_back(shape_frame(cur));
            sent_count <= sent_count + 1;
            busy = 0;
         end
         if (!busy) begin
            if (!staged && frame_q.size() != 0) begin
               staged_frame = frame_q.pop_front();
               staged = 1;
               gap_left = staged_frame.gap;
            end
            in_flight = sent_count + (accepted ? 1 : 0) - got_count;
            if (staged && gap_left == 0 && (!staged_frame.drain_first || in_flight == 0)) begin
               req_valid <= 1'b1;
               req_turn_pulse_us <= staged_frame.turn_p;
               req_drive_pulse_us <= staged_frame.drive_p;
               req_dome_pulse_us <= staged_frame.dome_p;
               req_kill_active <= staged_frame.kill;
               req_time_ms <= staged_frame.now;
               staged = 0;
            end else begin
               req_valid <= 1'b0;
               if (staged && gap_left > 0) gap_left--;
            end
         end
      end
   end

   // monitor and receiver
   always @(posedge clock) begin
      cmd_set_type want;
      bit          ready_next;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (cmd_expect_q.size() == 0) begin
               flag_error($sformatf("unexpected transaction: drive %0d turn %0d dome %0d",
                                    rsp_drive_cmd, rsp_turn_cmd, rsp_dome_cmd));
            end else begin
               want = cmd_expect_q.pop_front();
               if (rsp_drive_cmd !== want.drive || rsp_turn_cmd !== want.turn ||
                   rsp_dome_cmd !== want.dome || rsp_dome_changed !== want.changed) begin
                  flag_error($sformatf({"transaction %0d: expected drive %0d turn %0d ",
                                        "dome %0d changed %0b, got drive %0d turn %0d ",
                                        "dome %0d changed %0b"},
                                       got_count, want.drive, want.turn, want.dome,
                                       want.changed, rsp_drive_cmd, rsp_turn_cmd,
                                       rsp_dome_cmd, rsp_dome_changed));
               end
            end
            got_count <= got_count + 1;
            if (got_count % 64 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
            rx_stall = rx_quiet ? 0 : $urandom_range(0, 7);
            if (got_count == 150) rx_stall = LONG_HOLD;
         end
         if (rx_stall > 0) begin
            ready_next = 1'b0;
            rx_stall--;
         end else begin
            ready_next = 1'b1;
         end
         rsp_ready <= ready_next;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx, input int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_DATA_BITS'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_EXPO_POWER:      cfg_expo = value[1:0];
         CSR_DRIVE_LIMIT:     cfg_drive_limit = value[6:0];
         CSR_STICK_DEAD_ZONE: cfg_stick_dz = value[6:0];
         CSR_DOME_DEAD_ZONE:  cfg_dome_dz = value[6:0];
         CSR_DOME_BOOST:      cfg_boost = value[2:0];
         CSR_DOME_LIMIT:      cfg_dome_limit = value[6:0];
         CSR_DOME_LEFT_GAIN:  cfg_left_gain = value[9:0];
         default:             cfg_right_gain = value[9:0];
      endcase
   endtask

   task automatic write_all(input int expo, input int dlim, input int sdz, input int ddz,
                            input int boost, input int mlim, input int lgain, input int rgain);
      csr_write(CSR_EXPO_POWER, expo);
      csr_write(CSR_DRIVE_LIMIT, dlim);
      csr_write(CSR_STICK_DEAD_ZONE, sdz);
      csr_write(CSR_DOME_DEAD_ZONE, ddz);
      csr_write(CSR_DOME_BOOST, boost);
      csr_write(CSR_DOME_LIMIT, mlim);
      csr_write(CSR_DOME_LEFT_GAIN, lgain);
      csr_write(CSR_DOME_RIGHT_GAIN, rgain);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (frame_q.size() != 0 || staged || req_valid || sent_count != got_count) begin
         @(negedge clock);
      end
   endtask

   task automatic queue_frame(input int turn_p, input int drive_p, input int dome_p,
                              input bit kill, input logic [TIME_BITS-1:0] t,
                              input int gap, input bit drain_first);
      frame_type f;
      f.turn_p = PULSE_BITS'(turn_p);
      f.drive_p = PULSE_BITS'(drive_p);
      f.dome_p = PULSE_BITS'(dome_p);
      f.kill = kill;
      f.now = t;
      f.gap = 3'(gap);
      f.drain_first = drain_first;
      frame_q.push_back(f);
   endtask

   function automatic int stick_pulse();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll < 14) return $urandom_range(1000, 2000);
      if (roll < 16) return $urandom_range(1480, 1520);
      if (roll < 18) return $urandom_range(0, 65535);
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 65535;
         2:       return 999;
         default: return 2001;
      endcase
   endfunction

   task automatic queue_random(input int count);
      int i, burst_left, shape, roll, dome_p;
      bit quiet;
      burst_left = 0;
      shape = 0;
      quiet = 0;
      for (i = 0; i < count; i++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(3, 12);
            shape = $urandom_range(0, 9);
            quiet = ($urandom_range(0, 3) == 0);
         end
         burst_left--;
         if (shape < 3) dome_p = $urandom_range(1600, 2000);
         else if (shape < 5) dome_p = $urandom_range(1000, 1400);
         else if (shape < 8) dome_p = $urandom_range(1490, 1510);
         else dome_p = stick_pulse();
         roll = $urandom_range(0, 99);
         if (roll < 2) now_ms = $urandom;
         else if (roll < 12) now_ms = now_ms + $urandom_range(20, 60);
         else now_ms = now_ms + $urandom_range(0, 15);
         queue_frame(stick_pulse(), stick_pulse(), dome_p, $urandom_range(0, 11) == 0, now_ms,
                     quiet ? 0 : $urandom_range(0, 7), $urandom_range(0, 59) == 0);
      end
   endtask

   initial begin
      int ph;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset defaults: pulse extremes, out of range, kill, turn cap
      queue_frame(1500, 1500, 1500, 0, 0, $urandom_range(0, 7), 0);
      queue_frame(0, 0, 0, 0, 5, $urandom_range(0, 7), 0);
      queue_frame(65535, 65535, 65535, 0, 10, $urandom_range(0, 7), 0);
      queue_frame(1000, 2000, 1000, 0, 15, $urandom_range(0, 7), 0);
      queue_frame(2000, 1000, 2000, 0, 20, $urandom_range(0, 7), 0);
      queue_frame(999, 2001, 1499, 0, 25, $urandom_range(0, 7), 0);
      queue_frame(2000, 2000, 2000, 1, 30, $urandom_range(0, 7), 0);
      queue_frame(2000, 1900, 1500, 0, 35, $urandom_range(0, 7), 0);
      wait_idle();

      // flick coast, kill during coast, time wrap, stick dead zone edge
      write_all(1, 127, 10, 10, 2, 100, 256, 256);
      queue_frame(1500, 1500, 2000, 0, 100, $urandom_range(0, 7), 0);
      queue_frame(1500, 1500, 1500, 0, 110, $urandom_range(0, 7), 0);
      queue_frame(1500, 1500, 1500, 0, 139, $urandom_range(0, 7), 0);
      queue_frame(1500, 1500, 1500, 0, 140, $urandom_range(0, 7), 0);
      queue_frame(1500, 1500, 1000, 0, 200, $urandom_range(0, 7), 0);
      queue_frame(1500, 1500, 1000, 0, 205, $urandom_range(0, 7), 0);
      queue_frame(1500, 1500, 1500, 1, 210, $urandom_range(0, 7), 0);
      queue_frame(1500, 1500, 1800, 1, 215, $urandom_range(0, 7), 0);
      queue_frame(1500, 1500, 1500, 0, 300, $urandom_range(0, 7), 0);
      queue_frame(1500, 1500, 2000, 0, 32'hFFFF_FFF0, $urandom_range(0, 7), 0);
      queue_frame(1500, 1500, 1500, 0, 5, $urandom_range(0, 7), 0);
      queue_frame(1540, 1540, 1500, 0, 400, $urandom_range(0, 7), 0);
      queue_frame(1545, 1545, 1500, 0, 405, $urandom_range(0, 7), 0);
      wait_idle();

      for (ph = 0; ph < 8; ph++) begin
         case (ph)
            0: write_all(3, 127, 0, 20, 4, 127, 512, 512);
            1: write_all(0, 0, 127, 127, 0, 0, 0, 0);
            2: write_all(2, 64, 5, 8, 7, 127, 1023, 1023);
            default: write_all($urandom_range(0, 3), $urandom_range(0, 127),
                               $urandom_range(0, 40), $urandom_range(1, 60),
                               $urandom_range(0, 7), $urandom_range(0, 127),
                               $urandom_range(0, 1023), $urandom_range(0, 1023));
         endcase
         if (ph == 3) now_ms = 32'hFFFF_FC00;
         queue_random(185);
         wait_idle();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && cmd_expect_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
